// ----- hdl/ppe_pkg.sv -----
// Package with the constants, types and helper functions of the piecewise polynomial evaluator.
`default_nettype none
package ppe_pkg;

  localparam int MaxSegments = 64;
  localparam int MaxJoints   = 6;
  localparam int MaxDegree   = 5;
  localparam int Rows        = MaxDegree + 1;
  localparam int BpDepth     = MaxSegments + 1;
  localparam int BpAw        = $clog2(BpDepth);
  localparam int CoefDepth   = MaxSegments * Rows * MaxJoints;
  localparam int CoefAw      = $clog2(CoefDepth);

  localparam logic [1:0] CmdWrBp   = 2'd0;
  localparam logic [1:0] CmdWrCoef = 2'd1;
  localparam logic [1:0] CmdEval   = 2'd2;

  localparam logic [2:0] RegSegCount   = 3'd0;
  localparam logic [2:0] RegPolyDegree = 3'd1;
  localparam logic [2:0] RegJointCount = 3'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RDSC, S_CHK, S_BS_RD, S_BS_CMP, S_SEG, S_DX_RD, S_DX,
    S_LO, S_HI, S_CF, S_ADD, S_EMIT
  } state_t;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd140737488355327;
    lo = -66'sd140737488355328;
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd2147483647;
    lo = -48'sd2147483648;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  // Falling factorial k!/(k-order)! for order 0, 1 or 2.
  function automatic logic [4:0] ffact(input logic [2:0] k, input logic [1:0] order);
    logic [4:0] k5;
    k5 = {2'b00, k};
    case (order)
      2'd0: return 5'd1;
      2'd1: return k5;
      default: return 5'((k5 * (k5 - 5'd1)));
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ppe_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module ppe_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [64:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * 65'(b);
  end
endmodule
`default_nettype wire

// ----- hdl/piecewise_poly_evaluator_unit.sv -----
// Top level of the piecewise polynomial evaluator.
// Items enter on the in_* channel (valid/stall) and results leave on the out_* channel.
// A write command stores a breakpoint or a coefficient and gives one acknowledge item.
// An evaluate command range-checks the position against breakpoints 0 and segment_count,
// binary-searches the segment, then gives one item per joint, the last one marked by last.
// A position outside the table gives a single item with out_of_range set.
// An evaluation runs the range check and a binary search of s steps (s is at most 7),
// then for each joint the Horner terms (degree - order + 1 terms), each through the states
// LO, HI, CF and ADD, and then hands off the item in EMIT.
// The single shared multiplier is used three times per term, in LO, HI and CF.
// Only one item is in work at a time; in_stall is high during reset and from acceptance
// until the final result has been loaded into the output register.
// A stalled result holds in the output register and the sequencer waits for it to drain.
// Reset returns the sequencer to idle, empties the output register and sets the
// registers to segment_count 1, poly_degree 3, joint_count 6. The tables are not cleared.
// Configuration writes take effect at once and are meant for idle periods only.
`default_nettype none
module piecewise_poly_evaluator_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [6:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [6:0]         breakpoint_slot,
  input  wire logic [5:0]         segment_slot,
  input  wire logic [2:0]         power_row,
  input  wire logic [2:0]         joint_slot,
  input  wire logic signed [31:0] table_value,
  input  wire logic signed [31:0] position,
  input  wire logic [1:0]         deriv_order,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              joint_index,
  output logic signed [31:0]      result_value,
  output logic [5:0]              found_segment,
  output logic                    out_of_range,
  output logic                    is_write_ack,
  output logic                    last
);
  import ppe_pkg::*;

  state_t state, state_next;

  logic [6:0] segment_count;
  logic [2:0] poly_degree;
  logic [2:0] joint_count;
  logic [6:0] sc_eff;
  logic [2:0] dg_eff;
  logic [2:0] jc_eff;

  logic signed [31:0] bp_mem [0:BpDepth-1];
  logic signed [31:0] coef_mem [0:CoefDepth-1];
  logic [BpAw-1:0]    bp_addr;
  logic [CoefAw-1:0]  coef_addr;
  logic signed [31:0] bp_q;
  logic signed [31:0] coef_q;

  logic signed [31:0] pos;
  logic [1:0]         order;
  logic               kind_ack;
  logic               kind_oor;
  logic               below;
  logic [6:0]         first;
  logic [6:0]         n;
  logic [6:0]         half;
  logic [6:0]         mid;
  logic [6:0]         seg_w;
  logic [5:0]         seg;
  logic signed [31:0] dx;
  logic signed [47:0] acc;
  logic signed [47:0] acc_m;
  logic signed [64:0] plo;
  logic [2:0]         r;
  logic [2:0]         j;
  logic [2:0]         last_row;
  logic               no_terms;
  logic               slot_free;
  logic               last_item;
  logic               in_acc;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [32:0] dx_diff;

  ppe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  always_comb begin
    sc_eff = (segment_count == 7'd0) ? 7'd1 :
             (segment_count > 7'(MaxSegments)) ? 7'(MaxSegments) : segment_count;
    dg_eff = (poly_degree > 3'(MaxDegree)) ? 3'(MaxDegree) : poly_degree;
    jc_eff = (joint_count == 3'd0) ? 3'd1 :
             (joint_count > 3'(MaxJoints)) ? 3'(MaxJoints) : joint_count;
  end

  assign in_acc    = in_valid && !in_stall;
  assign half      = n >> 1;
  assign mid       = first + half;
  assign no_terms  = {1'b0, order} > dg_eff;
  assign last_row  = dg_eff - {1'b0, order};
  assign slot_free = !out_valid || !out_stall;
  assign last_item = kind_ack || kind_oor || (j == jc_eff - 3'd1);
  assign seg_w     = (first == 7'd0) ? 7'd0 :
                     ((first - 7'd1) > (sc_eff - 7'd1)) ? (sc_eff - 7'd1) : (first - 7'd1);
  assign dx_diff   = 33'(pos) - 33'(bp_q);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CmdEval) state_next = S_RD0;
          else if (command == CmdWrBp || command == CmdWrCoef) state_next = S_EMIT;
        end
      end
      S_RD0: state_next = S_RDSC;
      S_RDSC: state_next = S_CHK;
      S_CHK: state_next = (below || pos > bp_q) ? S_EMIT : S_BS_RD;
      S_BS_RD: state_next = (n == 7'd0) ? S_SEG : S_BS_CMP;
      S_BS_CMP: state_next = S_BS_RD;
      S_SEG: state_next = S_DX_RD;
      S_DX_RD: state_next = S_DX;
      S_DX: state_next = no_terms ? S_EMIT : S_LO;
      S_LO: state_next = S_HI;
      S_HI: state_next = S_CF;
      S_CF: state_next = S_ADD;
      S_ADD: state_next = (r == last_row) ? S_EMIT : S_LO;
      S_EMIT: begin
        if (slot_free) begin
          if (last_item) state_next = S_IDLE;
          else state_next = no_terms ? S_EMIT : S_LO;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = rst || (state != S_IDLE);
    bp_addr   = '0;
    mul_a     = '0;
    mul_b     = '0;
    coef_addr = CoefAw'((int'(seg) * Rows + int'(r)) * MaxJoints + int'(j));
    case (state)
      S_RDSC: bp_addr = BpAw'(sc_eff);
      S_BS_RD: bp_addr = BpAw'(mid);
      S_DX_RD: bp_addr = BpAw'(seg_w);
      S_LO: begin
        mul_a = {17'd0, acc[15:0]};
        mul_b = dx;
      end
      S_HI: begin
        mul_a = 33'($signed(acc[47:16]));
        mul_b = dx;
      end
      S_CF: begin
        mul_a = 33'(coef_q);
        mul_b = {27'd0, ffact(dg_eff - r, order)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    bp_q   <= bp_mem[bp_addr];
    coef_q <= coef_mem[coef_addr];
    if (in_acc && command == CmdWrBp && breakpoint_slot <= 7'(MaxSegments)) begin
      bp_mem[BpAw'(breakpoint_slot)] <= table_value;
    end
    if (in_acc && command == CmdWrCoef && int'(segment_slot) < MaxSegments &&
        power_row <= 3'(MaxDegree) && joint_slot < 3'(MaxJoints)) begin
      coef_mem[CoefAw'((int'(segment_slot) * Rows + int'(power_row)) * MaxJoints +
                       int'(joint_slot))] <= table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      segment_count <= 7'd1;
      poly_degree   <= 3'd3;
      joint_count   <= 3'd6;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          RegSegCount: segment_count <= cfg_data;
          RegPolyDegree: poly_degree <= cfg_data[2:0];
          RegJointCount: joint_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_EMIT && slot_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pos      <= position;
        order    <= (deriv_order == 2'd3) ? 2'd2 : deriv_order;
        kind_ack <= (command != CmdEval);
        kind_oor <= (command == CmdWrBp) ? (breakpoint_slot > 7'(MaxSegments)) :
                    (int'(segment_slot) >= MaxSegments || power_row > 3'(MaxDegree) ||
                     joint_slot >= 3'(MaxJoints));
        first    <= 7'd0;
        n        <= sc_eff + 7'd1;
        j        <= 3'd0;
        r        <= 3'd0;
        acc      <= '0;
      end
      S_RDSC: below <= pos < bp_q;
      S_CHK: kind_oor <= below || pos > bp_q;
      S_BS_CMP: begin
        if (!(pos < bp_q)) begin
          first <= mid + 7'd1;
          n     <= n - half - 7'd1;
        end else begin
          n <= half;
        end
      end
      S_SEG: seg <= seg_w[5:0];
      S_DX: begin
        if (dx_diff > 33'sd2147483647) dx <= 32'sh7FFFFFFF;
        else if (dx_diff < -33'sd2147483648) dx <= 32'sh80000000;
        else dx <= dx_diff[31:0];
      end
      S_HI: plo <= mul_p;
      S_CF: acc_m <= sat48(66'(mul_p) + 66'(plo >>> 16));
      S_ADD: begin
        acc <= sat48(66'(acc_m) + 66'(mul_p));
        if (r != last_row) r <= r + 3'd1;
      end
      S_EMIT: begin
        if (slot_free) begin
          joint_index   <= (kind_ack || kind_oor) ? 3'd0 : j;
          result_value  <= (kind_ack || kind_oor) ? 32'sd0 : sat32(acc);
          found_segment <= (kind_ack || kind_oor) ? 6'd0 : seg;
          out_of_range  <= kind_oor;
          is_write_ack  <= kind_ack;
          last          <= last_item;
          j             <= j + 3'd1;
          r             <= 3'd0;
          acc           <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
